[rtl/keccak_p200_permutation_unit_defines.svh]
// Assertion macros for the Keccak-p[200] permutation unit
`ifndef KECCAK_P200_PERMUTATION_UNIT_DEFINES_SVH
`define KECCAK_P200_PERMUTATION_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define KP200_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define KP200_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/kp200_pkg.sv]
// Types, constants and helpers for the Keccak-p[200] permutation unit
`timescale 1ns / 1ps

package kp200_pkg;

    localparam int LANES       = 25;
    localparam int FULL_ROUNDS = 18;
    localparam int POS_W       = 5;
    localparam int CNT_W       = 5;
    localparam int LANE_W      = 8;

    typedef logic [LANE_W-1:0] lane_t;
    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    localparam pos_t LAST_POS = pos_t'(LANES - 1);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ROUND,
        ST_EMIT
    } kp_state_t;

    localparam lane_t RC_TABLE [FULL_ROUNDS] = '{
        8'h01, 8'h82, 8'h8a, 8'h00, 8'h8b, 8'h01, 8'h81, 8'h09, 8'h8a,
        8'h88, 8'h09, 8'h0a, 8'h8b, 8'h8b, 8'h89, 8'h03, 8'h02, 8'h80
    };

    // rho offsets mod 8, indexed by x + 5*y
    localparam logic [2:0] RHO_TABLE [LANES] = '{
        3'd0, 3'd1, 3'd6, 3'd4, 3'd3,
        3'd4, 3'd4, 3'd6, 3'd7, 3'd4,
        3'd3, 3'd2, 3'd3, 3'd1, 3'd7,
        3'd1, 3'd5, 3'd7, 3'd5, 3'd0,
        3'd2, 3'd2, 3'd5, 3'd0, 3'd6
    };

    function automatic lane_t rotl8(lane_t v, logic [2:0] s);
        logic [2*LANE_W-1:0] w;
        w = {v, v} << s;
        return w[2*LANE_W-1:LANE_W];
    endfunction

endpackage

[rtl/keccak_p200_permutation_unit.sv]
// Keccak-p[200] permutation unit: byte-serial load, round core, byte-serial unload
// The unit takes a 200-bit Keccak state as 25 byte transactions (lane 0 first) into a
// 25-lane shift register, applies the last n of the 18 Keccak-f[200] rounds with
// n = min(round setting, MAX_ROUNDS), then returns the 25 permuted lanes in the same
// order with out_last on lane 24. One transaction moves one byte per cycle on each
// side while that neighbor keeps up, and the round logic works on the whole lane
// register, one round per cycle. No input is taken while rounds run or while the
// result is being unloaded. The round setting resets to 18 and should only be
// written while the unit is idle between blocks.
`timescale 1ns / 1ps
`include "keccak_p200_permutation_unit_defines.svh"

module keccak_p200_permutation_unit #(
    parameter int MAX_ROUNDS = 18
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  kp200_pkg::cnt_t         cfg_wdata,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  kp200_pkg::lane_t        state_byte,
    output logic                    out_valid,
    input  logic                    out_ready,
    output kp200_pkg::lane_t        out_byte,
    output logic                    out_last
);
    import kp200_pkg::*;

    kp_state_t state_reg, state_next;
    pos_t      pos_reg, pos_next;
    cnt_t      idx_reg, idx_next;
    cnt_t      rounds_cfg_reg;
    lane_t     lane_reg [LANES];

    cnt_t      n_eff;
    cnt_t      start_idx;
    lane_t     rc;
    logic      shift_en;
    logic      round_en;

    lane_t     c_col [5];
    lane_t     d_col [5];
    lane_t     b_lane [LANES];
    lane_t     round_out [LANES];

    // Rounds taken from the end of the table; MAX_ROUNDS caps the count taken from the register.
    assign n_eff     = (rounds_cfg_reg > cnt_t'(MAX_ROUNDS)) ? cnt_t'(MAX_ROUNDS)
                                                             : rounds_cfg_reg;
    assign start_idx = cnt_t'(FULL_ROUNDS) - n_eff;
    assign rc        = (idx_reg < cnt_t'(FULL_ROUNDS)) ? RC_TABLE[idx_reg] : '0;

    // One full round: theta, rho and pi, chi, iota
    always_comb
    begin
        for (int x = 0; x < 5; x++)
        begin
            c_col[x] = lane_reg[x] ^ lane_reg[x+5] ^ lane_reg[x+10] ^
                       lane_reg[x+15] ^ lane_reg[x+20];
        end
        for (int x = 0; x < 5; x++)
        begin
            d_col[x] = c_col[(x+4)%5] ^ rotl8(c_col[(x+1)%5], 3'd1);
        end
        for (int y = 0; y < 5; y++)
        begin
            for (int x = 0; x < 5; x++)
            begin
                b_lane[y + 5*((2*x + 3*y) % 5)] =
                    rotl8(lane_reg[x + 5*y] ^ d_col[x], RHO_TABLE[x + 5*y]);
            end
        end
        for (int y = 0; y < 5; y++)
        begin
            for (int x = 0; x < 5; x++)
            begin
                round_out[x + 5*y] = b_lane[x + 5*y] ^
                    (~b_lane[(x+1)%5 + 5*y] & b_lane[(x+2)%5 + 5*y]);
            end
        end
        round_out[0] = round_out[0] ^ rc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            pos_reg        <= '0;
            idx_reg        <= '0;
            rounds_cfg_reg <= cnt_t'(FULL_ROUNDS);
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            idx_reg   <= idx_next;
            if (cfg_we)
            begin
                rounds_cfg_reg <= cfg_wdata;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        idx_next   = idx_reg;
        shift_en   = 1'b0;
        round_en   = 1'b0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    shift_en = 1'b1;
                    if (pos_reg == LAST_POS)
                    begin
                        pos_next = '0;
                        idx_next = start_idx;
                        state_next = (start_idx == cnt_t'(FULL_ROUNDS)) ? ST_EMIT
                                                                          : ST_ROUND;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            ST_ROUND:
            begin
                round_en = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == cnt_t'(FULL_ROUNDS - 1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    shift_en = 1'b1;
                    if (pos_reg == LAST_POS)
                    begin
                        pos_next   = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
                pos_next   = '0;
            end
        endcase
    end

    // Lane register: shifts toward lane 0 on load and unload, updates in place on a round
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            for (int i = 0; i < LANES - 1; i++)
            begin
                lane_reg[i] <= lane_reg[i+1];
            end
            lane_reg[LANES-1] <= (state_reg == ST_LOAD) ? state_byte : lane_reg[0];
        end
        else if (round_en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                lane_reg[i] <= round_out[i];
            end
        end
    end

    assign out_byte = lane_reg[0];
    assign out_last = (pos_reg == LAST_POS);

    `KP200_ASSERT_NOW(a_no_overlap, out_valid, !in_ready, "input taken during unload")
    `KP200_ASSERT_NOW(a_idx_range, state_reg == ST_ROUND, idx_reg < cnt_t'(FULL_ROUNDS), "round index out of table")
    `KP200_ASSERT_NEXT(a_last_wraps, out_valid && out_ready && out_last, in_ready && (pos_reg == '0), "unit not ready after last byte")
    `KP200_ASSERT_NEXT(a_zero_rounds, in_valid && in_ready && (pos_reg == LAST_POS) && (n_eff == '0), out_valid, "zero-round block not unloaded at once")

endmodule
